>>> rtl/core/fsbc_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the size-budget fifo cache
package fsbc_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned ID_COUNT    = 256;

  localparam int unsigned QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FLAG_W = $clog2(ID_COUNT);

  localparam int unsigned ID_W   = 8;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CAP_W  = 20;
  localparam int unsigned CTR_W  = 32;
  localparam int unsigned EVC_W  = 7;

  // request codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } qent_t;

endpackage

>>> rtl/core/fsbc_ram.sv
`timescale 1ns / 1ps
// simple dual-port synchronous ram, one write and one registered read port
module fsbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fifo_size_budget_cache_core.sv
`timescale 1ns / 1ps
// fifo cache under a size budget: flag ram, queue ram and the sequencing fsm
// result: a lookup reads the flag ram in ST_LOOK; an insert passes ST_EVAL, with an ST_EVRD visit per evicted entry
// input: no new item is taken until the fsm is back in ST_IDLE
// the result register lets the next beat in while a result still waits
// reset: control clears at once, then a flag clearing pass over all ID_COUNT (256) flags
// during which no beat is accepted; configuration writes are taken throughout
module fifo_size_budget_cache_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fsbc_pkg::CAP_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [fsbc_pkg::ID_W-1:0]  item_id_i,
  input  logic [fsbc_pkg::SIZE_W-1:0] item_size_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic                       rejected_o,
  output logic [fsbc_pkg::EVC_W-1:0] evicted_count_o,
  output logic [fsbc_pkg::CAP_W-1:0] used_size_o,
  output logic [fsbc_pkg::CTR_W-1:0] hit_total_o,
  output logic [fsbc_pkg::CTR_W-1:0] miss_total_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_EVRD  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [fsbc_pkg::CAP_W-1:0]  cap_q;
  logic [fsbc_pkg::QIDX_W-1:0] head_q, head_d;
  logic [fsbc_pkg::CNT_W-1:0]  count_q, count_d;
  logic [fsbc_pkg::CAP_W-1:0]  used_q, used_d;
  logic [fsbc_pkg::CTR_W-1:0]  hits_q, hits_d, miss_q, miss_d;
  logic [fsbc_pkg::FLAG_W-1:0] clr_q, clr_d;

  logic                        req_q;
  logic [fsbc_pkg::ID_W-1:0]   id_q;
  logic [fsbc_pkg::SIZE_W-1:0] size_q;

  logic                        res_hit_q, res_hit_d, res_rej_q, res_rej_d;
  logic [fsbc_pkg::CNT_W-1:0]  evc_q, evc_d;

  logic                        out_valid_q, out_valid_d;
  logic                        out_hit_q, out_rej_q;
  logic [fsbc_pkg::EVC_W-1:0]  out_evc_q;
  logic [fsbc_pkg::CAP_W-1:0]  out_used_q;
  logic [fsbc_pkg::CTR_W-1:0]  out_hits_q, out_miss_q;

  // ram ports
  logic                        flag_we, flag_re, flag_wdata, flag_rdata;
  logic [fsbc_pkg::FLAG_W-1:0] flag_waddr, flag_raddr;
  logic                        q_we, q_re;
  logic [fsbc_pkg::QIDX_W-1:0] q_waddr, q_raddr;
  fsbc_pkg::qent_t             q_wdata, q_rdata;

  logic                        in_accept, out_free, finish, load_out;
  logic [fsbc_pkg::CAP_W:0]    need_sum;
  logic                        too_big, over_budget, q_full;

  fsbc_ram #(
    .WIDTH (1),
    .DEPTH (fsbc_pkg::ID_COUNT)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .re_i    (flag_re),
    .raddr_i (flag_raddr),
    .rdata_o (flag_rdata)
  );

  fsbc_ram #(
    .WIDTH ($bits(fsbc_pkg::qent_t)),
    .DEPTH (fsbc_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign need_sum = {1'b0, used_q}
                  + {{(fsbc_pkg::CAP_W + 1 - fsbc_pkg::SIZE_W){1'b0}}, size_q};
  assign too_big  = {{(fsbc_pkg::CAP_W - fsbc_pkg::SIZE_W){1'b0}}, size_q} > cap_q;
  assign over_budget = need_sum > {1'b0, cap_q};
  assign q_full      = (count_q == fsbc_pkg::CNT_W'(fsbc_pkg::QUEUE_DEPTH));

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    used_d     = used_q;
    hits_d     = hits_q;
    miss_d     = miss_q;
    clr_d      = clr_q;
    res_hit_d  = res_hit_q;
    res_rej_d  = res_rej_q;
    evc_d      = evc_q;
    finish     = 1'b0;
    flag_we    = 1'b0;
    flag_waddr = id_q[fsbc_pkg::FLAG_W-1:0];
    flag_wdata = 1'b0;
    flag_re    = 1'b0;
    flag_raddr = item_id_i[fsbc_pkg::FLAG_W-1:0];
    q_we       = 1'b0;
    q_waddr    = head_q + count_q[fsbc_pkg::QIDX_W-1:0];
    q_wdata    = '{id: id_q, size: size_q};
    q_re       = 1'b0;
    q_raddr    = head_q;
    case (state_q)
      ST_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == fsbc_pkg::FLAG_W'(fsbc_pkg::ID_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          res_hit_d = 1'b0;
          res_rej_d = 1'b0;
          evc_d     = '0;
          if (req_type_i == fsbc_pkg::REQ_LOOKUP) begin
            flag_re = 1'b1;
            state_d = ST_LOOK;
          end else begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_LOOK: begin
        res_hit_d = flag_rdata;
        if (flag_rdata) begin
          hits_d = hits_q + 1'b1;
        end else begin
          miss_d = miss_q + 1'b1;
        end
        finish = 1'b1;
      end
      ST_EVAL: begin
        if (too_big) begin
          res_rej_d = 1'b1;
          finish    = 1'b1;
        end else if ((count_q != '0) && (over_budget || q_full)) begin
          q_re    = 1'b1;
          state_d = ST_EVRD;
        end else begin
          // append at the tail and mark the id present
          q_we       = 1'b1;
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
          count_d    = count_q + 1'b1;
          used_d     = need_sum[fsbc_pkg::CAP_W-1:0];
          finish     = 1'b1;
        end
      end
      ST_EVRD: begin
        flag_we    = 1'b1;
        flag_waddr = q_rdata.id[fsbc_pkg::FLAG_W-1:0];
        used_d     = used_q
                   - {{(fsbc_pkg::CAP_W - fsbc_pkg::SIZE_W){1'b0}}, q_rdata.size};
        head_d     = head_q + 1'b1;
        count_d    = count_q - 1'b1;
        evc_d      = evc_q + 1'b1;
        state_d    = ST_EVAL;
      end
      ST_RESP: begin
        finish = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (finish) begin
      state_d = out_free ? ST_IDLE : ST_RESP;
    end
  end

  assign load_out = finish && out_free;

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cap_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      used_q      <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      used_q      <= used_d;
      hits_q      <= hits_d;
      miss_q      <= miss_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // beat and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= req_type_i;
      id_q   <= item_id_i;
      size_q <= item_size_i;
    end
    res_hit_q <= res_hit_d;
    res_rej_q <= res_rej_d;
    evc_q     <= evc_d;
    if (load_out) begin
      out_hit_q  <= res_hit_d;
      out_rej_q  <= res_rej_d;
      out_evc_q  <= fsbc_pkg::EVC_W'(evc_d);
      out_used_q <= used_d;
      out_hits_q <= hits_d;
      out_miss_q <= miss_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign rejected_o      = out_rej_q;
  assign evicted_count_o = out_evc_q;
  assign used_size_o     = out_used_q;
  assign hit_total_o     = out_hits_q;
  assign miss_total_o    = out_miss_q;

  // the stored request type steers nothing after dispatch; only lookups visit the flag read
  a_look_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOK |-> req_q == fsbc_pkg::REQ_LOOKUP)
    else $error("flag lookup state entered for an insert");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fsbc_pkg::CNT_W'(fsbc_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_empty_no_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> used_q == '0)
    else $error("size held with an empty queue");

  a_evrd_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVRD |-> $past(state_q) == ST_EVAL && $past(q_re))
    else $error("eviction without a queue read");

  a_flag_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flag_we && flag_re))
    else $error("flag ram read and write in one cycle");

endmodule
